// ===== sv/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants and types for the linear blend skinning unit.
// ----------------------------------------------------------------------------
package lbs_pkg;

   localparam int NUM_BONES_DEF      = 64;
   localparam int MAX_INFLUENCES_DEF = 4;
   localparam int PACKED_JOINTS      = 4;
   localparam int ELEMS_PER_BONE     = 12;
   localparam int BONE_W             = 6;
   localparam int WEIGHT_W           = 16;
   localparam int DATA_W             = 32;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SKIN  = 1'b1;

   // one bone matrix, element row*3+column
   typedef logic signed [DATA_W-1:0] matrix_type [ELEMS_PER_BONE];

   // per-lane result handed to the merge stage
   typedef struct packed {
      logic signed [63:0] cx;
      logic signed [63:0] cy;
      logic signed [63:0] cz;
   } lane_result_type;

endpackage

// ===== sv/lbs_if.sv =====
// ----------------------------------------------------------------------------
// lbs_req_if / lbs_rsp_if
// Valid/ready channels carrying skinning requests and skinned positions.
// ----------------------------------------------------------------------------
interface lbs_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [5:0]         bone_slot;
   logic [3:0]         element_slot;
   logic signed [31:0] element_value;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [2:0]         influence_count;
   logic [23:0]        joint_indices;
   logic [63:0]        joint_weights;
   modport source (output valid, cmd, bone_slot, element_slot, element_value,
                   pos_x, pos_y, pos_z, influence_count, joint_indices,
                   joint_weights, input ready);
   modport sink   (input valid, cmd, bone_slot, element_slot, element_value,
                   pos_x, pos_y, pos_z, influence_count, joint_indices,
                   joint_weights, output ready);
endinterface

interface lbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic               saturated;
   modport source (output valid, out_x, out_y, out_z, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ===== sv/lbs_lane.sv =====
// ----------------------------------------------------------------------------
// lbs_lane
// One influence lane: fetches its bone matrix from its own palette copy,
// then transforms, weights and returns the contribution.
// ----------------------------------------------------------------------------
module lbs_lane
   import lbs_pkg::*;
#(
   parameter int NUM_BONES = NUM_BONES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // palette write port (broadcast to every lane)
   input  logic                      wr_en,
   input  logic [$clog2(NUM_BONES*ELEMS_PER_BONE)-1:0] wr_addr,
   input  logic signed [DATA_W-1:0]  wr_data,
   // job
   input  logic                      start,
   input  logic                      active,
   input  logic [BONE_W-1:0]         bone,
   input  logic [WEIGHT_W-1:0]       weight,
   input  logic signed [DATA_W-1:0]  px,
   input  logic signed [DATA_W-1:0]  py,
   input  logic signed [DATA_W-1:0]  pz,
   output logic                      done,
   output lane_result_type           result
);

   localparam int DEPTH  = NUM_BONES * ELEMS_PER_BONE;
   localparam int ADDR_W = $clog2(DEPTH);

   // sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_SUM   = 3'd3;
   localparam logic [2:0] ST_WMUL  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic signed [DATA_W-1:0] palette [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   logic [2:0]        state_ff, state_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              use_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [WEIGHT_W-1:0] w_ff;
   logic signed [DATA_W-1:0] px_ff, py_ff, pz_ff;
   matrix_type        m_ff;
   logic signed [63:0] prod_ff [9];
   logic signed [63:0] p_ff [3];
   logic signed [63:0] res_ff [3];

   // palette copy, registered read
   always_ff @(posedge clock) begin
      if (wr_en) palette[wr_addr] <= wr_data;
      rd_data_ff <= palette[base_ff + ADDR_W'(cnt_ff)];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: if (start) begin state_in = ST_FETCH; cnt_in = '0; end
         ST_FETCH: begin
            // read data is registered and arrives in the cycle after its address
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(ELEMS_PER_BONE)) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_WMUL;
         ST_WMUL: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // job capture and datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         use_ff  <= active && (32'(bone) < NUM_BONES);
         base_ff <= ADDR_W'(32'(bone) * ELEMS_PER_BONE);
         w_ff    <= weight;
         px_ff   <= px;
         py_ff   <= py;
         pz_ff   <= pz;
      end
      if (state_ff == ST_FETCH && cnt_ff != 4'd0)
         m_ff[cnt_ff - 4'd1] <= rd_data_ff;
      if (state_ff == ST_MUL) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[c]   <= 64'(px_ff) * 64'(m_ff[c]);
            prod_ff[3+c] <= 64'(py_ff) * 64'(m_ff[3+c]);
            prod_ff[6+c] <= 64'(pz_ff) * 64'(m_ff[6+c]);
         end
      end
      if (state_ff == ST_SUM) begin
         for (int c = 0; c < 3; c++)
            p_ff[c] <= (prod_ff[c] >>> 16) + (prod_ff[3+c] >>> 16)
                     + (prod_ff[6+c] >>> 16) + 64'(m_ff[9+c]);
      end
      // exact floor(p*w/2^16); p fits in 51 bits so the product fits 68
      if (state_ff == ST_WMUL) begin
         for (int c = 0; c < 3; c++)
            res_ff[c] <= use_ff ?
               64'((72'(p_ff[c]) * $signed({56'd0, w_ff})) >>> 16) : 64'sd0;
      end
   end

   assign done      = (state_ff == ST_DONE);
   assign result.cx = res_ff[0];
   assign result.cy = res_ff[1];
   assign result.cz = res_ff[2];

endmodule

// ===== sv/lbs_merge.sv =====
// ----------------------------------------------------------------------------
// lbs_merge
// Sums the lane contributions and saturates to signed Q16.16.
// ----------------------------------------------------------------------------
module lbs_merge
   import lbs_pkg::*;
#(
   parameter int LANES = MAX_INFLUENCES_DEF
) (
   input  lane_result_type          lanes [LANES],
   output logic signed [DATA_W-1:0] out_x,
   output logic signed [DATA_W-1:0] out_y,
   output logic signed [DATA_W-1:0] out_z,
   output logic                     saturated
);

   logic signed [66:0] sx, sy, sz;
   logic ox_hi, ox_lo, oy_hi, oy_lo, oz_hi, oz_lo;

   // sum over lanes
   always_comb begin
      sx = '0; sy = '0; sz = '0;
      for (int l = 0; l < LANES; l++) begin
         sx = sx + 67'(lanes[l].cx);
         sy = sy + 67'(lanes[l].cy);
         sz = sz + 67'(lanes[l].cz);
      end
   end

   // clamp
   assign ox_hi = sx > 67'sh7FFFFFFF;
   assign ox_lo = sx < -67'sh80000000;
   assign oy_hi = sy > 67'sh7FFFFFFF;
   assign oy_lo = sy < -67'sh80000000;
   assign oz_hi = sz > 67'sh7FFFFFFF;
   assign oz_lo = sz < -67'sh80000000;
   assign out_x = ox_hi ? 32'sh7FFFFFFF : ox_lo ? 32'sh80000000 : sx[31:0];
   assign out_y = oy_hi ? 32'sh7FFFFFFF : oy_lo ? 32'sh80000000 : sy[31:0];
   assign out_z = oz_hi ? 32'sh7FFFFFFF : oz_lo ? 32'sh80000000 : sz[31:0];
   assign saturated = ox_hi | ox_lo | oy_hi | oy_lo | oz_hi | oz_lo;

endmodule

// ===== sv/linear_blend_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// A vertex skin runs from acceptance to the result register through the
// matrix fetch (twelve reads plus read latency) from each lane's palette
// copy, then the multiply, sum, weight and done stages. One vertex at a
// time: the next request is taken once the result has moved to the output
// register and that register is empty or being read. Synchronous reset clears
// control only; the palette is undefined until written.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning
   import lbs_pkg::*;
#(
   parameter int NUM_BONES      = NUM_BONES_DEF,
   parameter int MAX_INFLUENCES = MAX_INFLUENCES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lbs_req_if.sink   req,
   lbs_rsp_if.source rsp
);

   localparam int LANES  = (MAX_INFLUENCES < PACKED_JOINTS) ? MAX_INFLUENCES
                                                            : PACKED_JOINTS;
   localparam int ADDR_W = $clog2(NUM_BONES * ELEMS_PER_BONE);

   logic busy_ff, busy_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, wr_en, start;
   logic [2:0] count;
   logic [ADDR_W-1:0] wr_addr;
   logic [LANES-1:0] done;
   lane_result_type lane_res [LANES];
   logic signed [DATA_W-1:0] mx, my, mz;
   logic msat;
   logic signed [DATA_W-1:0] ox_ff, oy_ff, oz_ff;
   logic sat_ff;

   // handshake: one vertex in flight, output register frees the lanes
   assign req.ready = !busy_ff && !(rsp_valid_ff && !rsp.ready);
   assign accept    = req.valid && req.ready;
   assign start     = accept && (req.cmd == CMD_SKIN);
   assign wr_en     = accept && (req.cmd == CMD_WRITE)
                      && (32'(req.bone_slot) < NUM_BONES)
                      && (req.element_slot < 4'(ELEMS_PER_BONE));
   assign wr_addr   = ADDR_W'(32'(req.bone_slot) * ELEMS_PER_BONE
                              + 32'(req.element_slot));
   assign count     = (req.influence_count > 3'(LANES)) ? 3'(LANES)
                                                        : req.influence_count;

   // lanes
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      lbs_lane #(.NUM_BONES(NUM_BONES)) u_lane (
         .clock  (clock),
         .reset  (reset),
         .wr_en  (wr_en),
         .wr_addr(wr_addr),
         .wr_data(req.element_value),
         .start  (start),
         .active (3'(l) < count),
         .bone   (req.joint_indices[l*BONE_W +: BONE_W]),
         .weight (req.joint_weights[l*WEIGHT_W +: WEIGHT_W]),
         .px     (req.pos_x),
         .py     (req.pos_y),
         .pz     (req.pos_z),
         .done   (done[l]),
         .result (lane_res[l])
      );
   end

   lbs_merge #(.LANES(LANES)) u_merge (
      .lanes(lane_res), .out_x(mx), .out_y(my), .out_z(mz), .saturated(msat)
   );

   // control
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (start) busy_in = 1'b1;
      if (done[0]) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (done[0]) begin
         ox_ff  <= mx;
         oy_ff  <= my;
         oz_ff  <= mz;
         sat_ff <= msat;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_x     = ox_ff;
   assign rsp.out_y     = oy_ff;
   assign rsp.out_z     = oz_ff;
   assign rsp.saturated = sat_ff;

   // checks
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      done[0] |-> &done) else $error("lanes out of step");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !accept) else $error("request taken while busy");
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      done[0] |-> busy_ff) else $error("lane finished with no vertex");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done[0] |-> !rsp_valid_ff || rsp.ready) else $error("result overwritten");

endmodule

// ===== dv/lbs_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_tb_if
// Testbench copy of the channel interfaces is not needed: the RTL interfaces
// are reused. This file holds the shared testbench types for the skinning unit.
// ----------------------------------------------------------------------------
package lbs_tb_pkg;

   // one skinning or palette request as the sender offers it
   typedef struct {
      logic               cmd;
      logic [5:0]         bone_slot;
      logic [3:0]         element_slot;
      logic signed [31:0] element_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [2:0]         influence_count;
      logic [23:0]        joint_indices;
      logic [63:0]        joint_weights;
   } skin_request_type;

   // one skinned position
   typedef struct {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               saturated;
   } skinned_pos_type;

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Skinning unit testbench: loads bone palettes, skins vertices with zero to
// four weighted joints and checks each skinned position against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import lbs_pkg::*;
   import lbs_tb_pkg::*;

   localparam int NB = NUM_BONES_DEF;

   logic clock;
   logic reset;

   lbs_req_if req ();
   lbs_rsp_if rsp ();

   linear_blend_vertex_skinning dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   // predictor state
   logic signed [31:0] palette_copy [NB*ELEMS_PER_BONE];
   skinned_pos_type    expected_pos [$];

   int error_count;
   int skin_count;
   int write_count;
   int checked_count;
   int sat_count;

   // idling controls, percentages
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_off;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch %0s: got %h want %h (check %0d)", what, got, want,
               checked_count);
   endtask

   // floor of (a * b) / 2^16, exact
   function automatic logic signed [95:0] mul_floor16(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
      logic signed [127:0] prod;
      prod = 128'(a) * 128'(b);
      return 96'(prod >>> 16);
   endfunction

   // skinned position for one vertex request
   function automatic skinned_pos_type skin_vertex(input skin_request_type r);
      skinned_pos_type    res;
      logic signed [95:0] acc [3];
      logic signed [95:0] p;
      logic signed [63:0] pos [3];
      int                 cnt;
      int                 bone;
      logic signed [63:0] w;
      int                 base;
      pos[0] = 64'(r.pos_x);
      pos[1] = 64'(r.pos_y);
      pos[2] = 64'(r.pos_z);
      cnt = r.influence_count;
      if (cnt > MAX_INFLUENCES_DEF) cnt = MAX_INFLUENCES_DEF;
      if (cnt > PACKED_JOINTS) cnt = PACKED_JOINTS;
      for (int c = 0; c < 3; c++) acc[c] = '0;
      for (int j = 0; j < cnt; j++) begin
         bone = r.joint_indices[6*j +: 6];
         w = 64'({1'b0, r.joint_weights[16*j +: 16]});
         if (bone >= NB) continue;
         base = bone * ELEMS_PER_BONE;
         for (int c = 0; c < 3; c++) begin
            p = mul_floor16(pos[0], 64'(palette_copy[base + c]))
              + mul_floor16(pos[1], 64'(palette_copy[base + 3 + c]))
              + mul_floor16(pos[2], 64'(palette_copy[base + 6 + c]))
              + 96'(palette_copy[base + 9 + c]);
            acc[c] += mul_floor16(64'(p), w);
         end
      end
      res.saturated = 1'b0;
      for (int c = 0; c < 3; c++) begin
         logic signed [31:0] v;
         if (acc[c] > 96'sd2147483647) begin
            v = 32'h7fffffff;
            res.saturated = 1'b1;
         end else if (acc[c] < -96'sd2147483648) begin
            v = 32'h80000000;
            res.saturated = 1'b1;
         end else begin
            v = acc[c][31:0];
         end
         if (c == 0) res.out_x = v;
         else if (c == 1) res.out_y = v;
         else res.out_z = v;
      end
      return res;
   endfunction

   // offer one request, wait for acceptance, update the predictor
   task automatic send_request(input skin_request_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid           <= 1'b1;
      req.cmd             <= r.cmd;
      req.bone_slot       <= r.bone_slot;
      req.element_slot    <= r.element_slot;
      req.element_value   <= r.element_value;
      req.pos_x           <= r.pos_x;
      req.pos_y           <= r.pos_y;
      req.pos_z           <= r.pos_z;
      req.influence_count <= r.influence_count;
      req.joint_indices   <= r.joint_indices;
      req.joint_weights   <= r.joint_weights;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (r.cmd == CMD_WRITE) begin
         write_count++;
         if (r.bone_slot < NB && r.element_slot < ELEMS_PER_BONE)
            palette_copy[r.bone_slot*ELEMS_PER_BONE + r.element_slot] = r.element_value;
      end else begin
         skin_count++;
         expected_pos = {expected_pos, skin_vertex(r)};
      end
      // valid stays up; the next request or the drain takes it down
      @(negedge clock);
   endtask

   // request builders
   function automatic skin_request_type write_req(input int bone, input int elem,
                                                  input logic [31:0] value);
      skin_request_type r;
      r = '{default: '0};
      r.cmd = CMD_WRITE;
      r.bone_slot = 6'(bone);
      r.element_slot = 4'(elem);
      r.element_value = value;
      r.pos_x = $urandom();
      r.joint_weights = {$urandom(), $urandom()};
      return r;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return 32'($signed($urandom_range(131072)) - 65536);
         default: return 32'($signed($urandom_range(8192)) - 4096) <<< $urandom_range(14);
      endcase
   endfunction

   // palette bones that have been fully written
   bit bone_ready [NB];

   task automatic load_bone(input int bone, input bit extreme);
      for (int e = 0; e < ELEMS_PER_BONE; e++)
         send_request(write_req(bone, e, extreme ? rand_value() :
                      32'($signed($urandom_range(131072)) - 65536)));
      bone_ready[bone] = 1'b1;
   endtask

   function automatic skin_request_type vertex_req(input int cnt, input bit wild);
      skin_request_type r;
      int               picks [4];
      r = '{default: '0};
      r.cmd = CMD_SKIN;
      r.bone_slot = 6'($urandom());
      r.element_slot = 4'($urandom());
      r.element_value = $urandom();
      r.pos_x = wild ? rand_value() : 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      r.pos_y = wild ? rand_value() : 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      r.pos_z = wild ? rand_value() : 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      r.influence_count = 3'(cnt);
      r.joint_weights = {$urandom(), $urandom()};
      // every joint must name a loaded bone: unwritten entries may not be read
      for (int j = 0; j < 4; j++) begin
         do picks[j] = $urandom_range(NB - 1); while (!bone_ready[picks[j]]);
         r.joint_indices[6*j +: 6] = 6'(picks[j]);
      end
      return r;
   endfunction

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (expected_pos.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   // result checker
   initial begin
      skinned_pos_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (expected_pos.size() == 0) begin
               report_mismatch("unexpected out_x", rsp.out_x, 32'h0);
            end else begin
               want = expected_pos.pop_front();
               if (rsp.out_x !== want.out_x) report_mismatch("out_x", rsp.out_x, want.out_x);
               if (rsp.out_y !== want.out_y) report_mismatch("out_y", rsp.out_y, want.out_y);
               if (rsp.out_z !== want.out_z) report_mismatch("out_z", rsp.out_z, want.out_z);
               if (rsp.saturated !== want.saturated)
                  report_mismatch("saturated", 32'(rsp.saturated), 32'(want.saturated));
               if (want.saturated) sat_count++;
               checked_count++;
            end
         end
      end
   end

   // receiver ready, changed at the falling edge
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) rsp.ready <= 1'b0;
         else rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 20; i++) send_request(vertex_req($urandom_range(1, 4), 0));
      join
      wait_drained();
   endtask

   task automatic test_directed();
      skin_request_type r;
      // bone 0 identity, bone 63 extremes, bone 1 random
      for (int e = 0; e < ELEMS_PER_BONE; e++)
         send_request(write_req(0, e, (e == 0 || e == 4 || e == 8) ? 32'h10000 : 32'h0));
      bone_ready[0] = 1'b1;
      for (int e = 0; e < ELEMS_PER_BONE; e++)
         send_request(write_req(63, e, e[0] ? 32'h7fffffff : 32'h80000000));
      bone_ready[63] = 1'b1;
      // ignored writes: element slot out of range
      send_request(write_req(0, 12, 32'hdeadbeef));
      send_request(write_req(0, 15, 32'h12345678));
      load_bone(1, 0);
      // no influences
      r = vertex_req(0, 1);
      send_request(r);
      // identity, weight near one
      r = vertex_req(1, 1);
      r.joint_indices = '0;
      r.joint_weights = 64'hffff;
      send_request(r);
      // extreme position through extreme bone: saturates
      r = vertex_req(4, 0);
      r.pos_x = 32'h7fffffff; r.pos_y = 32'h80000000; r.pos_z = 32'h7fffffff;
      r.joint_indices = {4{6'd63}};
      r.joint_weights = '1;
      send_request(r);
      r.pos_x = 32'h80000000; r.pos_y = 32'h7fffffff; r.pos_z = 32'h80000000;
      send_request(r);
      // count above four is clamped
      for (int c = 5; c < 8; c++) send_request(vertex_req(c, 1));
      // zero weights
      r = vertex_req(4, 1);
      r.joint_weights = '0;
      send_request(r);
      wait_drained();
   endtask

   task automatic test_random(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            int b;
            b = $urandom_range(NB - 1);
            send_request(write_req(b, $urandom_range(ELEMS_PER_BONE - 1), rand_value()));
            if (!bone_ready[b]) begin
               // finish the bone so later reads stay inside written entries
               load_bone(b, $urandom_range(1));
            end
         end else if (pick < 11) begin
            // ignored write, out-of-range element slot
            send_request(write_req($urandom(), $urandom_range(12, 15), $urandom()));
         end else begin
            send_request(vertex_req($urandom_range(7), pick < 30));
         end
      end
      wait_drained();
   endtask

   // stimulus
   initial begin
      req.valid = 1'b0;
      req.cmd = CMD_WRITE;
      req.bone_slot = '0;
      req.element_slot = '0;
      req.element_value = '0;
      req.pos_x = '0;
      req.pos_y = '0;
      req.pos_z = '0;
      req.influence_count = '0;
      req.joint_indices = '0;
      req.joint_weights = '0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      for (int b = 2; b < 6; b++) load_bone(b, b[0]);
      test_random(200);
      send_idle_pct = 72;
      test_random(200);
      send_idle_pct = 0;
      recv_stall_pct = 72;
      test_random(200);
      send_idle_pct = 14;
      recv_stall_pct = 14;
      test_random(200);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_backpressure();
      test_random(150);

      $display("covered %0d palette writes and %0d vertices, %0d saturated",
               write_count, skin_count, sat_count);
      $display("%0d skinned positions checked, %0d errors", checked_count, error_count);
      if (error_count == 0 && expected_pos.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lbs_pkg.sv
sv/lbs_if.sv
sv/lbs_lane.sv
sv/lbs_merge.sv
sv/linear_blend_vertex_skinning.sv
dv/lbs_tb_if.sv
dv/tb_top.sv
